// ===== src/chip8_instruction_execute_core_assert.svh =====
// ----------------------------------------------------------------------------
// CHIP-8 execute core assertion macros
// Shared property macros for the port-level checker of the execute core.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define C8IE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chip8 execute core check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define C8IE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chip8 execute core check failed");

`endif

// ===== src/c8ie_pkg.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 execute core package
// Sizes, opcode constants, status codes and the control structs shared by
// the register file, the return stack, the execute unit and the top level.
// ----------------------------------------------------------------------------
package c8ie_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_LW      = $clog2(STACK_DEPTH + 1);

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [15:0] INS_CLS  = 16'h00E0;
  localparam logic [15:0] INS_RET  = 16'h00EE;
  localparam logic [7:0]  KK_SKP   = 8'h9E;
  localparam logic [7:0]  KK_SKNP  = 8'hA1;
  localparam logic [7:0]  KK_LDDT  = 8'h07;
  localparam logic [3:0]  VF_IDX   = 4'hF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STACK = 2'd1,
    ST_UNSUP = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_SYS  = 4'h0,
    OP_JP   = 4'h1,
    OP_CALL = 4'h2,
    OP_SE   = 4'h3,
    OP_SNE  = 4'h4,
    OP_SER  = 4'h5,
    OP_LD   = 4'h6,
    OP_ADD  = 4'h7,
    OP_ALU  = 4'h8,
    OP_SNER = 4'h9,
    OP_LDI  = 4'hA,
    OP_JPV0 = 4'hB,
    OP_RND  = 4'hC,
    OP_DRW  = 4'hD,
    OP_KEY  = 4'hE,
    OP_MISC = 4'hF
  } opgrp_t;

  typedef enum logic [3:0] {
    ALU_LD   = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_t;

  typedef struct packed {
    logic       wa_en;
    logic [3:0] wa_addr;
    logic [7:0] wa_data;
    logic       wf_en;
    logic [7:0] wf_data;
  } rf_wr_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [11:0] data;
  } stk_op_t;

endpackage

// ===== src/c8ie_regfile.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 general register file
// V0..VE live in a synchronous memory with two read ports and one write
// port; VF is a flip-flop. The most recent memory write is kept for
// forwarding, and per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module c8ie_regfile (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [3:0]         rd_addr_a,
  input  logic [3:0]         rd_addr_b,
  input  c8ie_pkg::rf_wr_t   wr,
  output logic [7:0]         rd_data_a,
  output logic [7:0]         rd_data_b
);

  logic [7:0]  mem [16];
  logic [7:0]  mem_a_r;
  logic [7:0]  mem_b_r;
  logic [3:0]  raddr_a_r;
  logic [3:0]  raddr_b_r;
  logic [15:0] vld_r;
  logic [7:0]  vf_r;
  logic        lw_vld_r;
  logic [3:0]  lw_addr_r;
  logic [7:0]  lw_data_r;
  logic        mem_we;

  assign mem_we = wr.wa_en && (wr.wa_addr != c8ie_pkg::VF_IDX);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr.wa_addr] <= wr.wa_data;
    end
    if (rd_en) begin
      mem_a_r   <= mem[rd_addr_a];
      mem_b_r   <= mem[rd_addr_b];
      raddr_a_r <= rd_addr_a;
      raddr_b_r <= rd_addr_b;
    end
    if (mem_we) begin
      lw_addr_r <= wr.wa_addr;
      lw_data_r <= wr.wa_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vf_r     <= '0;
      lw_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[wr.wa_addr] <= 1'b1;
        lw_vld_r          <= 1'b1;
      end
      if (wr.wf_en) begin
        vf_r <= wr.wf_data;
      end else if (wr.wa_en && (wr.wa_addr == c8ie_pkg::VF_IDX)) begin
        vf_r <= wr.wa_data;
      end
    end
  end

  always_comb begin
    priority if (raddr_a_r == c8ie_pkg::VF_IDX) begin
      rd_data_a = vf_r;
    end else if (lw_vld_r && (lw_addr_r == raddr_a_r)) begin
      rd_data_a = lw_data_r;
    end else if (vld_r[raddr_a_r]) begin
      rd_data_a = mem_a_r;
    end else begin
      rd_data_a = '0;
    end
  end

  always_comb begin
    priority if (raddr_b_r == c8ie_pkg::VF_IDX) begin
      rd_data_b = vf_r;
    end else if (lw_vld_r && (lw_addr_r == raddr_b_r)) begin
      rd_data_b = lw_data_r;
    end else if (vld_r[raddr_b_r]) begin
      rd_data_b = mem_b_r;
    end else begin
      rd_data_b = '0;
    end
  end

endmodule

// ===== src/c8ie_stack.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 return stack
// Return addresses in a synchronous memory. The entry below the stack level
// is read every cycle, so the top is ready for a return; a push at the same
// edge is forwarded from the last-write register.
// ----------------------------------------------------------------------------
module c8ie_stack (
  input  logic                           clk,
  input  logic                           rst_n,
  input  c8ie_pkg::stk_op_t              op,
  output logic [c8ie_pkg::STK_LW-1:0]    level,
  output logic [11:0]                    top
);

  logic [11:0]                 mem [c8ie_pkg::STACK_DEPTH];
  logic [c8ie_pkg::STK_LW-1:0] level_r;
  logic [c8ie_pkg::STK_LW-1:0] level_nxt;
  logic [c8ie_pkg::STK_AW-1:0] rd_idx_nxt;
  logic [c8ie_pkg::STK_AW-1:0] rd_idx_r;
  logic [11:0]                 rdata_r;
  logic                        lw_vld_r;
  logic [c8ie_pkg::STK_AW-1:0] lw_idx_r;
  logic [11:0]                 lw_data_r;
  logic [c8ie_pkg::STK_AW-1:0] wr_idx;

  assign wr_idx = c8ie_pkg::STK_AW'(level_r);

  always_comb begin
    priority if (op.push) begin
      level_nxt = level_r + 1'b1;
    end else if (op.pop) begin
      level_nxt = level_r - 1'b1;
    end else begin
      level_nxt = level_r;
    end
    if (level_nxt == '0) begin
      rd_idx_nxt = '0;
    end else begin
      rd_idx_nxt = c8ie_pkg::STK_AW'(level_nxt - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[wr_idx] <= op.data;
      lw_idx_r    <= wr_idx;
      lw_data_r   <= op.data;
    end
    rdata_r  <= mem[rd_idx_nxt];
    rd_idx_r <= rd_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      lw_vld_r <= 1'b0;
    end else begin
      level_r <= level_nxt;
      if (op.push) begin
        lw_vld_r <= 1'b1;
      end
    end
  end

  assign level = level_r;
  assign top   = (lw_vld_r && (lw_idx_r == rd_idx_r)) ? lw_data_r : rdata_r;

endmodule

// ===== src/c8ie_exec.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 execute unit
// Decodes one opcode and computes the next program counter, the status,
// the register file writes, the stack operation and the reported write.
// ----------------------------------------------------------------------------
module c8ie_exec (
  input  logic [15:0]                  ins,
  input  logic [15:0]                  keys,
  input  logic [7:0]                   dly,
  input  logic [7:0]                   rnd,
  input  logic [7:0]                   va,
  input  logic [7:0]                   vb,
  input  logic [11:0]                  pc,
  input  logic [c8ie_pkg::STK_LW-1:0]  level,
  input  logic [11:0]                  top,
  output c8ie_pkg::status_t            status,
  output logic [11:0]                  next_pc,
  output c8ie_pkg::rf_wr_t             rf_wr,
  output c8ie_pkg::stk_op_t            stk,
  output logic                         rep_written,
  output logic [3:0]                   rep_num,
  output logic [7:0]                   rep_val
);

  logic [3:0]  x;
  logic [3:0]  n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [11:0] pc2;
  logic [11:0] pc4;
  logic [8:0]  sum9;
  logic        pressed;

  assign x       = ins[11:8];
  assign n       = ins[3:0];
  assign kk      = ins[7:0];
  assign nnn     = ins[11:0];
  assign pc2     = pc + 12'd2;
  assign pc4     = pc + 12'd4;
  assign sum9    = {1'b0, va} + {1'b0, vb};
  assign pressed = (va[7:4] == 4'h0) && keys[va[3:0]];

  always_comb begin
    status      = c8ie_pkg::ST_OK;
    next_pc     = pc2;
    rf_wr       = '0;
    stk         = '0;
    rep_written = 1'b0;
    rep_num     = '0;
    rep_val     = '0;
    rf_wr.wa_addr = x;

    unique case (c8ie_pkg::opgrp_t'(ins[15:12]))
      c8ie_pkg::OP_SYS: begin
        if (ins == c8ie_pkg::INS_CLS) begin
          status = c8ie_pkg::ST_UNSUP;
        end else if (ins == c8ie_pkg::INS_RET) begin
          if (level == '0) begin
            status = c8ie_pkg::ST_STACK;
          end else begin
            stk.pop = 1'b1;
            next_pc = top;
          end
        end
      end
      c8ie_pkg::OP_JP: begin
        next_pc = nnn;
      end
      c8ie_pkg::OP_CALL: begin
        if (level >= c8ie_pkg::STK_LW'(c8ie_pkg::STACK_DEPTH)) begin
          status = c8ie_pkg::ST_STACK;
        end else begin
          stk.push = 1'b1;
          stk.data = pc2;
          next_pc  = nnn;
        end
      end
      c8ie_pkg::OP_SE: begin
        if (va == kk) next_pc = pc4;
      end
      c8ie_pkg::OP_SNE: begin
        if (va != kk) next_pc = pc4;
      end
      c8ie_pkg::OP_SER: begin
        if (n != 4'h0) begin
          status = c8ie_pkg::ST_UNSUP;
        end else if (va == vb) begin
          next_pc = pc4;
        end
      end
      c8ie_pkg::OP_SNER: begin
        if (n != 4'h0) begin
          status = c8ie_pkg::ST_UNSUP;
        end else if (va != vb) begin
          next_pc = pc4;
        end
      end
      c8ie_pkg::OP_LD: begin
        rf_wr.wa_en   = 1'b1;
        rf_wr.wa_data = kk;
      end
      c8ie_pkg::OP_ADD: begin
        rf_wr.wa_en   = 1'b1;
        rf_wr.wa_data = va + kk;
      end
      c8ie_pkg::OP_ALU: begin
        rf_wr.wa_en = 1'b1;
        unique case (c8ie_pkg::alu_t'(n))
          c8ie_pkg::ALU_LD:  rf_wr.wa_data = vb;
          c8ie_pkg::ALU_OR:  rf_wr.wa_data = va | vb;
          c8ie_pkg::ALU_AND: rf_wr.wa_data = va & vb;
          c8ie_pkg::ALU_XOR: rf_wr.wa_data = va ^ vb;
          c8ie_pkg::ALU_ADD: begin
            rf_wr.wa_data = sum9[7:0];
            rf_wr.wf_en   = 1'b1;
            rf_wr.wf_data = {7'b0, sum9[8]};
          end
          c8ie_pkg::ALU_SUB: begin
            rf_wr.wa_data = va - vb;
            rf_wr.wf_en   = 1'b1;
            rf_wr.wf_data = {7'b0, (va >= vb)};
          end
          c8ie_pkg::ALU_SUBN: begin
            rf_wr.wa_data = vb - va;
            rf_wr.wf_en   = 1'b1;
            rf_wr.wf_data = {7'b0, (vb >= va)};
          end
          c8ie_pkg::ALU_SHR: begin
            rf_wr.wa_data = {1'b0, va[7:1]};
            rf_wr.wf_en   = (x != c8ie_pkg::VF_IDX);
            rf_wr.wf_data = {7'b0, va[0]};
          end
          c8ie_pkg::ALU_SHL: begin
            rf_wr.wa_data = {va[6:0], 1'b0};
            rf_wr.wf_en   = (x != c8ie_pkg::VF_IDX);
            rf_wr.wf_data = {7'b0, va[7]};
          end
          default: begin
            rf_wr.wa_en = 1'b0;
            status      = c8ie_pkg::ST_UNSUP;
          end
        endcase
      end
      c8ie_pkg::OP_LDI: begin
        next_pc = pc2;
      end
      c8ie_pkg::OP_JPV0: begin
        next_pc = nnn + {4'h0, va};
      end
      c8ie_pkg::OP_RND: begin
        rf_wr.wa_en   = 1'b1;
        rf_wr.wa_data = rnd & kk;
      end
      c8ie_pkg::OP_DRW: begin
        status = c8ie_pkg::ST_UNSUP;
      end
      c8ie_pkg::OP_KEY: begin
        if (kk == c8ie_pkg::KK_SKP) begin
          if (pressed) next_pc = pc4;
        end else if (kk == c8ie_pkg::KK_SKNP) begin
          if (!pressed) next_pc = pc4;
        end else begin
          status = c8ie_pkg::ST_UNSUP;
        end
      end
      c8ie_pkg::OP_MISC: begin
        if (kk == c8ie_pkg::KK_LDDT) begin
          rf_wr.wa_en   = 1'b1;
          rf_wr.wa_data = dly;
        end else begin
          status = c8ie_pkg::ST_UNSUP;
        end
      end
      default: begin
        status = c8ie_pkg::ST_UNSUP;
      end
    endcase

    // The flag-setting ALU ops write VF last; shifts write Vx last.
    if (rf_wr.wa_en) begin
      rep_written = 1'b1;
      if (rf_wr.wf_en && (rf_wr.wf_data[7:1] == 7'h0) &&
          (c8ie_pkg::opgrp_t'(ins[15:12]) == c8ie_pkg::OP_ALU) &&
          ((c8ie_pkg::alu_t'(n) == c8ie_pkg::ALU_ADD) ||
           (c8ie_pkg::alu_t'(n) == c8ie_pkg::ALU_SUB) ||
           (c8ie_pkg::alu_t'(n) == c8ie_pkg::ALU_SUBN))) begin
        rep_num = c8ie_pkg::VF_IDX;
        rep_val = rf_wr.wf_data;
      end else begin
        rep_num = x;
        rep_val = rf_wr.wa_data;
      end
    end

    if (status != c8ie_pkg::ST_OK) begin
      next_pc     = pc;
      rf_wr       = '0;
      stk         = '0;
      rep_written = 1'b0;
      rep_num     = '0;
      rep_val     = '0;
    end
  end

endmodule

// ===== src/chip8_instruction_execute_core.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 instruction execute core
// Executes one CHIP-8 opcode per input word against a memory-based register
// file and return stack, and returns one result word per instruction.
//
//   Channel  Direction  tdata (low bit first)                    tuser
//   in_      slave      instruction, key_state, delay_value,     -
//                       random_byte (48 bits)
//   out_     master     next_pc, reg_written, reg_number,        status
//                       reg_value, zero fill (32 bits)
//
// One instruction per cycle sustained while the output is not stalled; an
// accepted input word is registered together with its register file reads,
// and its result word is then registered in the output register.
// Register file and stack writes are forwarded, so back-to-back dependent
// instructions need no stall. Reset gives PC 0x200, registers zero and an
// empty stack. A stalled output holds the execute stage and the input.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // instruction, key_state, delay_value, random_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // next_pc, reg_written, reg_number, reg_value, zeros
  output logic [1:0]  out_tuser   // status
);

  logic                          in_fire;
  logic                          adv;
  logic                          s1_vld_r;
  logic [15:0]                   ins_r;
  logic [15:0]                   keys_r;
  logic [7:0]                    dly_r;
  logic [7:0]                    rnd_r;
  logic [11:0]                   pc_r;
  logic [3:0]                    rd_addr_a;
  logic [7:0]                    va;
  logic [7:0]                    vb;
  logic [c8ie_pkg::STK_LW-1:0]   level;
  logic [11:0]                   top;
  c8ie_pkg::status_t             ex_status;
  logic [11:0]                   ex_next_pc;
  c8ie_pkg::rf_wr_t              ex_rf_wr;
  c8ie_pkg::stk_op_t             ex_stk;
  logic                          ex_written;
  logic [3:0]                    ex_num;
  logic [7:0]                    ex_val;
  c8ie_pkg::rf_wr_t              rf_wr;
  c8ie_pkg::stk_op_t             stk_op;
  logic                          out_vld_r;
  logic [31:0]                   out_data_r;
  logic [1:0]                    out_user_r;

  assign adv       = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  assign rd_addr_a = (c8ie_pkg::opgrp_t'(in_tdata[15:12]) == c8ie_pkg::OP_JPV0) ?
                     4'h0 : in_tdata[11:8];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ins_r  <= in_tdata[15:0];
      keys_r <= in_tdata[31:16];
      dly_r  <= in_tdata[39:32];
      rnd_r  <= in_tdata[47:40];
    end
    if (adv) begin
      out_data_r <= {7'b0, ex_val, ex_num, ex_written, ex_next_pc};
      out_user_r <= ex_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= c8ie_pkg::PC_RESET;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        pc_r      <= ex_next_pc;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_comb begin
    rf_wr       = ex_rf_wr;
    rf_wr.wa_en = ex_rf_wr.wa_en && adv;
    rf_wr.wf_en = ex_rf_wr.wf_en && adv;
    stk_op      = ex_stk;
    stk_op.push = ex_stk.push && adv;
    stk_op.pop  = ex_stk.pop && adv;
  end

  c8ie_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (in_tdata[7:4]),
    .wr        (rf_wr),
    .rd_data_a (va),
    .rd_data_b (vb)
  );

  c8ie_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (stk_op),
    .level (level),
    .top   (top)
  );

  c8ie_exec u_exec (
    .ins         (ins_r),
    .keys        (keys_r),
    .dly         (dly_r),
    .rnd         (rnd_r),
    .va          (va),
    .vb          (vb),
    .pc          (pc_r),
    .level       (level),
    .top         (top),
    .status      (ex_status),
    .next_pc     (ex_next_pc),
    .rf_wr       (ex_rf_wr),
    .stk         (ex_stk),
    .rep_written (ex_written),
    .rep_num     (ex_num),
    .rep_val     (ex_val)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/c8ie_checker.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 execute core port checker
// Watches the result channel of the execute core and is bound to its top.
// ----------------------------------------------------------------------------
`include "chip8_instruction_execute_core_assert.svh"

module c8ie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `C8IE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `C8IE_ASSERT_NOW(a_err_no_write, out_tvalid && (out_tuser != c8ie_pkg::ST_OK), out_tdata[12] == 1'b0)
  `C8IE_ASSERT_NOW(a_nowrite_zero, out_tvalid && !out_tdata[12], out_tdata[24:13] == 12'h000)

endmodule

bind chip8_instruction_execute_core c8ie_checker u_c8ie_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CHIP-8 instruction execute core testbench
// Streams opcodes with random operand words into the core and checks every
// result word against a cycle-free shadow of the register file, program
// counter, index register and return stack. Both channels idle and stall at
// random, and one long output hold fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module testbench;
  import c8ie_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    status_t     st;
    logic [11:0] pc;
    logic        wr;
    logic [3:0]  num;
    logic [7:0]  val;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // instruction, key_state, delay_value, random_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;      // next_pc, reg_written, reg_number, reg_value, zeros
  logic [1:0]  out_tuser;      // status

  logic [7:0]  shadow_v [16];
  logic [11:0] shadow_pc;
  logic [11:0] shadow_i;
  logic [11:0] shadow_stack [STACK_DEPTH];
  int          shadow_sp;
  logic        wr_seen;
  logic [3:0]  wr_idx;
  logic [7:0]  wr_data;

  exec_result_t pending_results [$];
  int           mismatches = 0;
  bit           gaps_on = 1'b1;
  bit           rx_random = 1'b1;
  int           hold_len = 0;
  int           hold_req = 0;

  chip8_instruction_execute_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void set_v(input logic [3:0] r, input logic [7:0] v);
    shadow_v[r] = v;
    wr_seen = 1'b1;
    wr_idx = r;
    wr_data = v;
  endfunction

  task automatic execute_shadow(input logic [15:0] ins, input logic [15:0] keys,
                                input logic [7:0] dly, input logic [7:0] rnd);
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn, nxt, skp;
    logic [8:0]  sum;
    logic        pressed;
    status_t     st;
    x = ins[11:8];
    y = ins[7:4];
    n = ins[3:0];
    kk = ins[7:0];
    nnn = ins[11:0];
    nxt = shadow_pc + 12'd2;
    skp = shadow_pc + 12'd4;
    vx = shadow_v[x];
    vy = shadow_v[y];
    st = ST_OK;
    wr_seen = 1'b0;
    wr_idx = '0;
    wr_data = '0;
    pressed = (vx < 8'd16) && keys[vx[3:0]];
    case (opgrp_t'(ins[15:12]))
      OP_SYS: begin
        if (ins == INS_CLS) begin
          st = ST_UNSUP;
        end else if (ins == INS_RET) begin
          if (shadow_sp == 0) begin
            st = ST_STACK;
          end else begin
            shadow_sp--;
            nxt = shadow_stack[shadow_sp];
          end
        end
      end
      OP_JP: nxt = nnn;
      OP_CALL: begin
        if (shadow_sp >= STACK_DEPTH) begin
          st = ST_STACK;
        end else begin
          shadow_stack[shadow_sp] = nxt;
          shadow_sp++;
          nxt = nnn;
        end
      end
      OP_SE:  if (vx == kk) nxt = skp;
      OP_SNE: if (vx != kk) nxt = skp;
      OP_SER: begin
        if (n != 4'd0) st = ST_UNSUP;
        else if (vx == vy) nxt = skp;
      end
      OP_LD:  set_v(x, kk);
      OP_ADD: set_v(x, vx + kk);
      OP_ALU: begin
        case (alu_t'(n))
          ALU_LD:  set_v(x, vy);
          ALU_OR:  set_v(x, vx | vy);
          ALU_AND: set_v(x, vx & vy);
          ALU_XOR: set_v(x, vx ^ vy);
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            set_v(x, sum[7:0]);
            set_v(VF_IDX, {7'd0, sum[8]});
          end
          ALU_SUB: begin
            set_v(x, vx - vy);
            set_v(VF_IDX, (vx >= vy) ? 8'd1 : 8'd0);
          end
          ALU_SHR: begin
            set_v(VF_IDX, {7'd0, vx[0]});
            set_v(x, {1'b0, vx[7:1]});
          end
          ALU_SUBN: begin
            set_v(x, vy - vx);
            set_v(VF_IDX, (vy >= vx) ? 8'd1 : 8'd0);
          end
          ALU_SHL: begin
            set_v(VF_IDX, {7'd0, vx[7]});
            set_v(x, {vx[6:0], 1'b0});
          end
          default: st = ST_UNSUP;
        endcase
      end
      OP_SNER: begin
        if (n != 4'd0) st = ST_UNSUP;
        else if (vx != vy) nxt = skp;
      end
      OP_LDI:  shadow_i = nnn;
      OP_JPV0: nxt = nnn + {4'd0, shadow_v[0]};
      OP_RND:  set_v(x, rnd & kk);
      OP_DRW:  st = ST_UNSUP;
      OP_KEY: begin
        if (kk == KK_SKP) begin
          if (pressed) nxt = skp;
        end else if (kk == KK_SKNP) begin
          if (!pressed) nxt = skp;
        end else begin
          st = ST_UNSUP;
        end
      end
      default: begin
        if (kk == KK_LDDT) set_v(x, dly);
        else st = ST_UNSUP;
      end
    endcase
    if (st != ST_OK) begin
      nxt = shadow_pc;
      wr_seen = 1'b0;
      wr_idx = '0;
      wr_data = '0;
    end
    shadow_pc = nxt;
    pending_results.push_back('{st, nxt, wr_seen, wr_idx, wr_data});
  endtask

  task automatic send_word(input logic [15:0] ins, input logic [15:0] keys,
                           input logic [7:0] dly, input logic [7:0] rnd);
    int r;
    int gap;
    in_tdata <= {rnd, dly, keys, ins};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    execute_shadow(ins, keys, dly, rnd);
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 30);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Key skips see the key that Vx names pressed about half of the time.
  task automatic send_op(input logic [15:0] ins);
    logic [15:0] keys;
    logic [7:0]  vx;
    keys = 16'($urandom);
    vx = shadow_v[ins[11:8]];
    if (opgrp_t'(ins[15:12]) == OP_KEY && vx < 8'd16 && $urandom_range(0, 1) == 1)
      keys[vx[3:0]] = 1'($urandom);
    send_word(ins, keys, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [15:0] pick_instruction();
    opgrp_t      grp;
    logic [3:0]  x, y;
    logic [7:0]  kk;
    logic [11:0] nnn;
    alu_t        alu_ops [9];
    int          r;
    alu_ops = '{ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                ALU_SUBN, ALU_SHL};
    x = 4'($urandom);
    y = 4'($urandom);
    kk = 8'($urandom);
    nnn = 12'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom);
    grp = opgrp_t'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    case (grp)
      OP_SYS: begin
        if (r < 45) return INS_RET;
        if (r < 55) return INS_CLS;
        return {OP_SYS, nnn};
      end
      OP_SE, OP_SNE: begin
        if (r < 50) kk = shadow_v[x];
        return {grp, x, kk};
      end
      OP_SER, OP_SNER: begin
        if (r < 40) y = x;
        return {grp, x, y, (r < 90) ? 4'd0 : 4'($urandom_range(1, 15))};
      end
      OP_LD: begin
        if (r < 35) kk = 8'($urandom_range(0, 15));
        return {OP_LD, x, kk};
      end
      OP_ALU: begin
        if (r < 85) return {OP_ALU, x, y, 4'(alu_ops[$urandom_range(0, 8)])};
        return {OP_ALU, x, y, 4'($urandom)};
      end
      OP_KEY: begin
        if (r < 45) return {OP_KEY, x, KK_SKP};
        if (r < 90) return {OP_KEY, x, KK_SKNP};
        return {OP_KEY, x, kk};
      end
      OP_MISC: begin
        if (r < 60) return {OP_MISC, x, KK_LDDT};
        return {OP_MISC, x, kk};
      end
      default: return {grp, nnn};
    endcase
  endfunction

  task automatic test_directed();
    send_op({OP_LD, 4'h0, 8'hFF});
    send_op({OP_LD, 4'h1, 8'hFF});
    send_op({OP_ALU, 4'h0, 4'h1, ALU_ADD});
    send_op({OP_LD, 4'hA, 8'h05});
    send_op({OP_LD, 4'hB, 8'h0A});
    send_op({OP_ALU, 4'hA, 4'hB, ALU_SUB});
    send_op({OP_ALU, 4'hB, 4'hA, ALU_SUBN});
    send_op({OP_ALU, 4'hA, 4'hB, ALU_SHR});
    send_op({OP_ALU, 4'hA, 4'hB, ALU_SHL});
    send_op({OP_ALU, 4'hA, 4'hB, ALU_OR});
    send_op({OP_ALU, 4'hA, 4'hB, ALU_AND});
    send_op({OP_ALU, 4'hA, 4'hB, ALU_XOR});
    send_op({OP_ALU, 4'hA, 4'hB, ALU_LD});
    send_op(16'h8AB8);
    send_op(16'h8ABF);
    send_op({OP_SE, 4'hA, 8'hF1});
    send_op({OP_SNE, 4'hA, 8'hF1});
    send_op({OP_SER, 4'hA, 4'hB, 4'h0});
    send_op({OP_SER, 4'hA, 4'hB, 4'h1});
    send_op({OP_SNER, 4'hA, 4'hB, 4'h0});
    send_op({OP_ADD, 4'hF, 8'hFF});
    send_op({OP_LDI, 12'hFFF});
    send_op({OP_JPV0, 12'hFFF});
    send_word({OP_RND, 4'h3, 8'hFF}, 16'h0000, 8'h00, 8'hA5);
    send_op({OP_DRW, 12'h123});
    send_op(INS_CLS);
    send_op(INS_RET);
    send_op({OP_CALL, 12'hFFE});
    send_op(INS_RET);
    send_op({OP_SYS, 12'hABC});
    send_op({OP_LD, 4'hC, 8'h03});
    send_word({OP_KEY, 4'hC, KK_SKP}, 16'h0008, 8'h00, 8'h00);
    send_word({OP_KEY, 4'hC, KK_SKNP}, 16'h0000, 8'h00, 8'h00);
    send_op({OP_KEY, 4'hC, 8'h55});
    send_op({OP_LD, 4'hD, 8'h20});
    send_word({OP_KEY, 4'hD, KK_SKP}, 16'hFFFF, 8'h00, 8'h00);
    send_word({OP_MISC, 4'h6, KK_LDDT}, 16'h0000, 8'hFF, 8'h00);
    send_op({OP_MISC, 4'h6, 8'h0A});
    send_op({OP_JP, 12'hFFE});
    send_op({OP_SNE, 4'h0, 8'h00});
    wait_drained();
  endtask

  task automatic test_stack_limits();
    while (shadow_sp < STACK_DEPTH) send_op({OP_CALL, 12'($urandom)});
    send_op({OP_CALL, 12'($urandom)});
    while (shadow_sp > 0) send_op(INS_RET);
    send_op(INS_RET);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        gaps_on = (i % 300 != 100);
        rx_random = (i % 300 != 200);
      end
      send_op(pick_instruction());
    end
    gaps_on = 1'b1;
    rx_random = 1'b1;
    wait_drained();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_len = 300;
    hold_req++;
    for (int i = 0; i < 50; i++) send_op(pick_instruction());
    wait_drained();
    gaps_on = 1'b1;
    for (int i = 0; i < 30; i++) send_op(pick_instruction());
    wait_drained();
  endtask

  always @(posedge clk) begin
    static int stall_left = 0;
    static int hold_seen = 0;
    int r;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      stall_left = hold_len;
    end
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!rx_random) begin
      out_tready <= 1'b1;
    end else if (r < 4) begin
      stall_left = $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= (r >= 25);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word %0h, status %0d", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.st, out_tuser);
        check_field("next_pc", want.pc, out_tdata[11:0]);
        check_field("reg_written", want.wr, out_tdata[12]);
        check_field("reg_number", want.num, out_tdata[16:13]);
        check_field("reg_value", want.val, out_tdata[24:17]);
        check_field("zero fill", 0, out_tdata[31:25]);
      end
    end
  end

  always @(posedge clk) begin
    static int quiet_cycles = 0;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no word moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) shadow_v[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) shadow_stack[i] = '0;
    shadow_pc = PC_RESET;
    shadow_i = '0;
    shadow_sp = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_stack_limits();
    test_random(700);
    test_backpressure();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/c8ie_pkg.sv
src/c8ie_regfile.sv
src/c8ie_stack.sv
src/c8ie_exec.sv
src/chip8_instruction_execute_core.sv
src/c8ie_checker.sv
tb/testbench.sv
